>>> src/ucdp_pkg.sv
// Shared types and constants for the USB configuration descriptor parser.
`default_nettype none

package ucdp_pkg;

   // Descriptor type codes and minimum lengths
   localparam logic [7:0] DT_CONFIG     = 8'd2;
   localparam logic [7:0] DT_INTERFACE  = 8'd4;
   localparam logic [7:0] DT_ENDPOINT   = 8'd5;
   localparam logic [7:0] CONFIG_MIN_LEN = 8'd9;
   localparam logic [7:0] IFACE_MIN_LEN  = 8'd9;
   localparam logic [7:0] EP_MIN_LEN     = 8'd7;
   localparam logic [7:0] CHAIN_MIN_LEN  = 8'd2;

   // Most records one byte can produce
   localparam int MAX_RECS = 3;

   typedef enum logic [2:0] {
      KIND_HEADER = 3'd0,
      KIND_IFACE  = 3'd1,
      KIND_EXTRA  = 3'd2,
      KIND_EP     = 3'd3,
      KIND_STATUS = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_TOO_MANY = 2'd2
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  iface_slot;
      logic [4:0]  ep_slot;
      logic [15:0] desc_offset;
      logic [15:0] extra_len;
      logic [55:0] field_bytes;
      status_type  status;
   } rec_type;

   // Records produced by one byte, slot 0 first
   typedef struct packed {
      logic [1:0]               count;
      rec_type [MAX_RECS-1:0]   recs;
   } bundle_type;

endpackage

`default_nettype wire

>>> src/usb_config_descriptor_parser.sv
// Top level of the USB configuration descriptor parser.
`default_nettype none

// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    data_byte, final_byte (one buffer byte)
// rsp      out        rsp_valid/stall    one record: kind, slots, offset, extent,
//                                        field bytes, status, last_of_run
//
// Flow: a byte waits in the input register, then its records (0 to 3) land in
// the result register and leave one per cycle while rsp_stall is low. Bytes
// that make at most one record flow at one per cycle while rsp_stall is low;
// a byte with several records holds the input until its last record is taken.
// Reset: synchronous, clears walk state and both valid flags; no clearing pass.
// Stalls: rsp_stall holds the current record; req_stall rises when the input
// register is full and its records cannot move into the result register.
module usb_config_descriptor_parser #(
   parameter int MAX_INTERFACES = 32,
   parameter int MAX_ENDPOINTS  = 31
) (
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_final_byte,

   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [2:0]        rsp_record_kind,
   output logic [4:0]        rsp_iface_slot,
   output logic [4:0]        rsp_ep_slot,
   output logic [15:0]       rsp_desc_offset,
   output logic [15:0]       rsp_extra_len,
   output logic [55:0]       rsp_field_bytes,
   output logic [1:0]        rsp_status_code,
   output logic              rsp_last_of_run
);

   // input register
   logic        a_valid_ff, a_valid_in;
   logic [7:0]  a_byte_ff;
   logic        a_final_ff;
   logic        accept;
   logic        advance;
   logic        free;

   ucdp_pkg::bundle_type bundle;
   ucdp_pkg::rec_type    rsp_rec;

   // the buffered byte moves on once the result register can take its records
   assign advance    = a_valid_ff && free;
   assign req_stall  = a_valid_ff && !free;
   assign accept     = req_valid && !req_stall;
   assign a_valid_in = accept ? 1'b1 : (advance ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_byte_ff  <= req_data_byte;
         a_final_ff <= req_final_byte;
      end
   end

   // walk state advances exactly when a byte leaves the input register
   ucdp_walker #(
      .MAX_INTERFACES (MAX_INTERFACES),
      .MAX_ENDPOINTS  (MAX_ENDPOINTS)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (a_byte_ff),
      .final_byte (a_final_ff),
      .bundle     (bundle)
   );

   ucdp_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .bundle    (bundle),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_rec   (rsp_rec),
      .rsp_last  (rsp_last_of_run)
   );

   assign rsp_record_kind = rsp_rec.kind;
   assign rsp_iface_slot  = rsp_rec.iface_slot;
   assign rsp_ep_slot     = rsp_rec.ep_slot;
   assign rsp_desc_offset = rsp_rec.desc_offset;
   assign rsp_extra_len   = rsp_rec.extra_len;
   assign rsp_field_bytes = rsp_rec.field_bytes;
   assign rsp_status_code = rsp_rec.status;

   // a status record always ends its byte's run
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind == ucdp_pkg::KIND_STATUS |-> rsp_last_of_run)
      else $error("status record not last of run");

   // records of a byte never overwrite ones still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_valid |-> !rsp_stall && rsp_last_of_run)
      else $error("result register overwritten");

   // a final byte always produces at least one record, its status record
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      advance |-> bundle.count != 2'd0 || !a_final_ff)
      else $error("final byte produced no status record");

endmodule

`default_nettype wire

>>> src/ucdp_walker.sv
// Descriptor walk state and per-byte record generation.
`default_nettype none

module ucdp_walker #(
   parameter int MAX_INTERFACES = 32,
   parameter int MAX_ENDPOINTS  = 31
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        data_byte,
   input  wire logic              final_byte,
   output ucdp_pkg::bundle_type   bundle
);

   localparam int IcW = $clog2(MAX_INTERFACES + 1);
   localparam int EcW = $clog2(MAX_ENDPOINTS + 1);

   logic [15:0]            pos_ff, pos_in;
   logic [15:0]            total_ff, total_in;
   logic [15:0]            desc_start_ff, desc_start_in;
   logic [7:0]             cur_len_ff, cur_len_in;
   logic [7:0]             desc_type_ff, desc_type_in;
   logic [55:0]            collect_ff, collect_in;
   logic [IcW-1:0]         iface_count_ff, iface_count_in;
   logic [EcW-1:0]         ep_count_ff, ep_count_in;
   logic                   iface_open_ff, iface_open_in;
   logic [15:0]            extra_start_ff, extra_start_in;
   logic                   extra_open_ff, extra_open_in;
   ucdp_pkg::status_type   error_ff, error_in;

   logic [16:0]            pos_ext;
   logic [16:0]            total_ext;
   logic [16:0]            desc_end;
   logic [7:0]             rel;
   logic [2:0]             lane;
   logic [1:0]             n;
   ucdp_pkg::rec_type [ucdp_pkg::MAX_RECS-1:0] recs;
   ucdp_pkg::status_type   final_status;

   // Extra-extent record for the most recent interface
   function automatic ucdp_pkg::rec_type extra_rec(input logic [IcW-1:0] count,
                                                   input logic [15:0] start,
                                                   input logic [15:0] stop);
      ucdp_pkg::rec_type r;
      logic [31:0]       slot;
      slot          = 32'(count) - 32'd1;
      r             = '0;
      r.kind        = ucdp_pkg::KIND_EXTRA;
      r.iface_slot  = slot[4:0];
      r.desc_offset = start;
      r.extra_len   = stop - start;
      return r;
   endfunction

   assign pos_ext   = {1'b0, pos_ff};
   assign total_ext = {1'b0, total_ff};
   assign desc_end  = {1'b0, desc_start_ff} + 17'(cur_len_ff);
   assign rel       = 8'(pos_ff - desc_start_ff);

   always_comb begin
      logic [31:0] slot_tmp;
      pos_in         = pos_ff;
      total_in       = total_ff;
      desc_start_in  = desc_start_ff;
      cur_len_in     = cur_len_ff;
      desc_type_in   = desc_type_ff;
      collect_in     = collect_ff;
      iface_count_in = iface_count_ff;
      ep_count_in    = ep_count_ff;
      iface_open_in  = iface_open_ff;
      extra_start_in = extra_start_ff;
      extra_open_in  = extra_open_ff;
      error_in       = error_ff;
      recs           = '0;
      n              = 2'd0;
      lane           = 3'd0;
      final_status   = ucdp_pkg::STATUS_OK;
      slot_tmp       = 32'd0;

      if (error_ff == ucdp_pkg::STATUS_OK) begin
         if (pos_ff < 16'd9) begin
            // configuration header bytes
            lane = 3'(pos_ff - 16'd2);
            if (pos_ff == 16'd0) begin
               desc_start_in = '0;
               cur_len_in    = data_byte;
               collect_in    = '0;
            end else if (pos_ff == 16'd1) begin
               desc_type_in = data_byte;
            end else begin
               collect_in[lane*8 +: 8] = data_byte;
            end
            if (pos_ff == 16'd3) begin
               total_in = collect_in[15:0];
            end
            if (pos_ff == 16'd8) begin
               if (desc_type_ff != ucdp_pkg::DT_CONFIG ||
                   cur_len_ff < ucdp_pkg::CONFIG_MIN_LEN ||
                   total_ff < {8'd0, cur_len_ff}) begin
                  error_in = ucdp_pkg::STATUS_INVALID;
               end else begin
                  recs[n].kind        = ucdp_pkg::KIND_HEADER;
                  recs[n].field_bytes = collect_in;
                  n = n + 2'd1;
               end
            end
         end else begin
            if (pos_ext == desc_end && pos_ext + 17'd2 <= total_ext) begin
               // length byte of the next chained descriptor
               if (data_byte < ucdp_pkg::CHAIN_MIN_LEN ||
                   {8'd0, data_byte} > total_ff - pos_ff) begin
                  error_in = ucdp_pkg::STATUS_INVALID;
               end else begin
                  desc_start_in = pos_ff;
                  cur_len_in    = data_byte;
                  desc_type_in  = '0;
                  collect_in    = '0;
               end
            end else if (pos_ext < desc_end && pos_ff < total_ff) begin
               lane = 3'(rel - 8'd2);
               if (rel == 8'd1) begin
                  desc_type_in = data_byte;
                  if (((data_byte == ucdp_pkg::DT_INTERFACE) &&
                       (cur_len_ff >= ucdp_pkg::IFACE_MIN_LEN)) ||
                      ((data_byte == ucdp_pkg::DT_ENDPOINT) &&
                       (cur_len_ff >= ucdp_pkg::EP_MIN_LEN) && iface_open_ff)) begin
                     if (extra_open_ff) begin
                        recs[n] = extra_rec(iface_count_ff, extra_start_ff,
                                            desc_start_ff);
                        n = n + 2'd1;
                        extra_open_in = 1'b0;
                     end
                  end
               end else if (rel >= 8'd2 && rel <= 8'd8) begin
                  collect_in[lane*8 +: 8] = data_byte;
               end

               if (rel == 8'd8 && desc_type_ff == ucdp_pkg::DT_INTERFACE &&
                   cur_len_ff >= ucdp_pkg::IFACE_MIN_LEN) begin
                  if (collect_in[15:8] != 8'd0) begin
                     // alternate setting: ignored along with its endpoints
                     iface_open_in = 1'b0;
                  end else if (iface_count_ff >= IcW'(MAX_INTERFACES)) begin
                     error_in = ucdp_pkg::STATUS_TOO_MANY;
                  end else begin
                     slot_tmp            = 32'(iface_count_ff);
                     recs[n].kind        = ucdp_pkg::KIND_IFACE;
                     recs[n].iface_slot  = slot_tmp[4:0];
                     recs[n].desc_offset = desc_start_ff;
                     recs[n].field_bytes = collect_in;
                     n = n + 2'd1;
                     iface_count_in = iface_count_ff + IcW'(1);
                     ep_count_in    = '0;
                     iface_open_in  = 1'b1;
                     extra_start_in = desc_start_ff + 16'(cur_len_ff);
                     extra_open_in  = 1'b1;
                  end
               end

               if (rel == 8'd6 && desc_type_ff == ucdp_pkg::DT_ENDPOINT &&
                   cur_len_ff >= ucdp_pkg::EP_MIN_LEN && iface_open_ff) begin
                  if (ep_count_ff >= EcW'(MAX_ENDPOINTS)) begin
                     error_in = ucdp_pkg::STATUS_TOO_MANY;
                  end else begin
                     slot_tmp            = 32'(iface_count_ff) - 32'd1;
                     recs[n].kind        = ucdp_pkg::KIND_EP;
                     recs[n].iface_slot  = slot_tmp[4:0];
                     slot_tmp            = 32'(ep_count_ff);
                     recs[n].ep_slot     = slot_tmp[4:0];
                     recs[n].desc_offset = desc_start_ff;
                     recs[n].field_bytes = collect_in;
                     n = n + 2'd1;
                     ep_count_in = ep_count_ff + EcW'(1);
                  end
               end
            end
         end

         // last byte inside the total length closes any open extent
         if (error_in == ucdp_pkg::STATUS_OK && pos_ff >= 16'd8 &&
             pos_ext + 17'd1 == {1'b0, total_in} && extra_open_in) begin
            recs[n] = extra_rec(iface_count_in, extra_start_in, total_in);
            n = n + 2'd1;
            extra_open_in = 1'b0;
         end
      end

      if (final_byte) begin
         final_status = error_in;
         if (error_in == ucdp_pkg::STATUS_OK &&
             (pos_ff < 16'd8 || pos_ext + 17'd1 < {1'b0, total_in} ||
              iface_count_in == '0)) begin
            final_status = ucdp_pkg::STATUS_INVALID;
         end
         recs[n].kind   = ucdp_pkg::KIND_STATUS;
         recs[n].status = final_status;
         n = n + 2'd1;
         pos_in         = '0;
         total_in       = '0;
         desc_start_in  = '0;
         cur_len_in     = '0;
         desc_type_in   = '0;
         collect_in     = '0;
         iface_count_in = '0;
         ep_count_in    = '0;
         iface_open_in  = 1'b0;
         extra_start_in = '0;
         extra_open_in  = 1'b0;
         error_in       = ucdp_pkg::STATUS_OK;
      end else if (pos_ff != 16'hFFFF) begin
         pos_in = pos_ff + 16'd1;
      end
   end

   assign bundle.count = n;
   assign bundle.recs  = recs;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         total_ff       <= '0;
         desc_start_ff  <= '0;
         cur_len_ff     <= '0;
         desc_type_ff   <= '0;
         collect_ff     <= '0;
         iface_count_ff <= '0;
         ep_count_ff    <= '0;
         iface_open_ff  <= 1'b0;
         extra_start_ff <= '0;
         extra_open_ff  <= 1'b0;
         error_ff       <= ucdp_pkg::STATUS_OK;
      end else if (step) begin
         pos_ff         <= pos_in;
         total_ff       <= total_in;
         desc_start_ff  <= desc_start_in;
         cur_len_ff     <= cur_len_in;
         desc_type_ff   <= desc_type_in;
         collect_ff     <= collect_in;
         iface_count_ff <= iface_count_in;
         ep_count_ff    <= ep_count_in;
         iface_open_ff  <= iface_open_in;
         extra_start_ff <= extra_start_in;
         extra_open_ff  <= extra_open_in;
         error_ff       <= error_in;
      end
   end

endmodule

`default_nettype wire

>>> src/ucdp_serializer.sv
// Result register: holds one byte's records and sends them out one per cycle while rsp_stall is low.
`default_nettype none

module ucdp_serializer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire ucdp_pkg::bundle_type bundle,
   output logic                     free,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output ucdp_pkg::rec_type        rsp_rec,
   output logic                     rsp_last
);

   logic [1:0]   count_ff, count_in;
   logic [1:0]   idx_ff, idx_in;
   ucdp_pkg::rec_type [ucdp_pkg::MAX_RECS-1:0] recs_ff, recs_in;
   logic         take;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_last  = (idx_ff == count_ff - 2'd1);
   assign take      = rsp_valid && !rsp_stall;
   assign free      = !rsp_valid || (take && rsp_last);
   assign rsp_rec   = recs_ff[idx_ff];

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      recs_in  = recs_ff;
      if (load) begin
         count_in = bundle.count;
         idx_in   = 2'd0;
         recs_in  = bundle.recs;
      end else if (take) begin
         if (rsp_last) begin
            count_in = 2'd0;
            idx_in   = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         idx_ff   <= 2'd0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      recs_ff <= recs_in;
   end

endmodule

`default_nettype wire
